>>> hw/rtl/gated_linear_recurrence_scan_core_assert.svh
// ----------------------------------------------------------------------------
// gated linear recurrence scan core - assertion macros
// concurrent checks on a clock with a synchronous active-low reset
// ----------------------------------------------------------------------------
`ifndef GATED_LINEAR_RECURRENCE_SCAN_CORE_ASSERT_SVH
`define GATED_LINEAR_RECURRENCE_SCAN_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define GLRS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("glrs check failed");

// antecedent implies consequent in the next cycle
`define GLRS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("glrs check failed");

`else

`define GLRS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define GLRS_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/glrs_pkg.sv
// ----------------------------------------------------------------------------
// glrs_pkg
// constants and fixed-point helpers for the gated linear recurrence scan
// ----------------------------------------------------------------------------
package glrs_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned CHANNELS  = 256;
  localparam int unsigned CH_W      = $clog2(CHANNELS);
  localparam int unsigned FRAC_BITS = 16;
  localparam int unsigned PROD_W    = 2 * DATA_W;

  localparam logic signed [PROD_W-1:0] ROUND_C = (PROD_W'(1) <<< FRAC_BITS) >>> 1;
  localparam logic signed [PROD_W-1:0] SAT_MAX = 64'sd2147483647;
  localparam logic signed [PROD_W-1:0] SAT_MIN = -64'sd2147483648;

  localparam logic signed [DATA_W-1:0] DATA_MAX = 32'sh7fffffff;
  localparam logic signed [DATA_W-1:0] DATA_MIN = 32'sh80000000;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic [CH_W-1:0]          chan_t;

  // round to nearest (ties up), drop the fraction, saturate to 32 bits
  function automatic data_t round_sat(input prod_t p);
    prod_t s;
    s = (p + ROUND_C) >>> FRAC_BITS;
    if (s > SAT_MAX) begin
      return DATA_MAX;
    end else if (s < SAT_MIN) begin
      return DATA_MIN;
    end
    return s[DATA_W-1:0];
  endfunction

  // saturating 32-bit add
  function automatic data_t sat_add(input data_t a, input data_t b);
    logic signed [DATA_W:0] s;
    s = {a[DATA_W-1], a} + {b[DATA_W-1], b};
    if (s[DATA_W] != s[DATA_W-1]) begin
      return s[DATA_W] ? DATA_MIN : DATA_MAX;
    end
    return s[DATA_W-1:0];
  endfunction

endpackage

>>> hw/rtl/gated_linear_recurrence_scan_core.sv
// ----------------------------------------------------------------------------
// gated linear recurrence scan core
// per-channel forward recurrence and backward gradient step, Q16.16
//
// input beats carry mode, channel, sequence flags and gate/value/aux;
// every input beat produces exactly one result beat, in order.
// forward: cell = round(prev * gate) + value, prev = aux at sequence start,
// else the stored word for the channel; the new cell is written back.
// backward: grad = value + carry (zero at the last step), outputs grad and
// round(grad * aux); carry round(grad * gate) is written back and returned as
// grad_init at time step zero.
// a result moves from stage 1 through stage 4 into the output register.
// throughput: one beat per cycle while channels differ and out_stall is low;
// a beat whose channel is still in one of the four stages behind the store
// read waits until that write has landed, so a lone channel waits on each one.
// a stalled result is held in the output register while the stages behind it
// keep filling; in_stall rises once they are all full.
// reset clears only the stage valids; the channel store is not cleared and a
// channel must open with a sequence-start beat before it is read.
// ----------------------------------------------------------------------------
module gated_linear_recurrence_scan_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_mode,
  input  logic [glrs_pkg::CH_W-1:0]          in_channel,
  input  logic                               in_seq_start,
  input  logic                               in_seq_end,
  input  logic signed [glrs_pkg::DATA_W-1:0] in_gate,
  input  logic signed [glrs_pkg::DATA_W-1:0] in_value,
  input  logic signed [glrs_pkg::DATA_W-1:0] in_aux,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [glrs_pkg::DATA_W-1:0] out_cell_out,
  output logic signed [glrs_pkg::DATA_W-1:0] out_grad_input,
  output logic signed [glrs_pkg::DATA_W-1:0] out_grad_gate,
  output logic signed [glrs_pkg::DATA_W-1:0] out_grad_init,
  output logic                               out_grad_init_valid
);

  `include "gated_linear_recurrence_scan_core_assert.svh"

  // channel store, one word per channel
  glrs_pkg::data_t mem [glrs_pkg::CHANNELS];
  glrs_pkg::data_t rd_data_r;

  // stage valids
  logic v1_r, v2_r, v3_r, v4_r, out_valid_r;
  logic en1, en2, en3, en4, s1_free;
  logic hazard, in_acc, wr_en;

  // stage 1: store read data arrives
  logic            mode1_r, start1_r, end1_r;
  glrs_pkg::chan_t ch1_r;
  glrs_pkg::data_t gate1_r, value1_r, aux1_r;
  glrs_pkg::data_t opnd_nxt;

  // stage 2: multipliers
  logic            mode2_r, end2_r;
  glrs_pkg::chan_t ch2_r;
  glrs_pkg::data_t a2_r, gate2_r, value2_r, aux2_r;
  glrs_pkg::prod_t pg_nxt, pa_nxt;

  // stage 3: rounding
  logic            mode3_r, end3_r;
  glrs_pkg::chan_t ch3_r;
  glrs_pkg::prod_t pg3_r, pa3_r;
  glrs_pkg::data_t a3_r, value3_r;

  // stage 4: forward add, store write
  logic            mode4_r, end4_r;
  glrs_pkg::chan_t ch4_r;
  glrs_pkg::data_t mg4_r, ma4_r, a4_r, value4_r;
  glrs_pkg::data_t cell_nxt, wr_data;

  // output register
  glrs_pkg::data_t cell_out_r, grad_input_r, grad_gate_r, grad_init_r;
  logic            grad_init_valid_r;

  // each stage moves on when the one ahead is empty or moving
  assign en4     = !out_valid_r || !out_stall;
  assign en3     = !v4_r || en4;
  assign en2     = !v3_r || en3;
  assign en1     = !v2_r || en2;
  assign s1_free = !v1_r || en1;

  // hold a beat whose channel is still on its way to the store
  assign hazard = (v1_r && (ch1_r == in_channel)) ||
                  (v2_r && (ch2_r == in_channel)) ||
                  (v3_r && (ch3_r == in_channel)) ||
                  (v4_r && (ch4_r == in_channel));

  assign in_stall = !s1_free || hazard;
  assign in_acc   = in_valid && !in_stall;
  assign wr_en    = v4_r && en4;

  always_comb begin
    if (!mode1_r) begin
      opnd_nxt = start1_r ? aux1_r : rd_data_r;
    end else begin
      opnd_nxt = glrs_pkg::sat_add(value1_r, start1_r ? '0 : rd_data_r);
    end
  end

  assign pg_nxt = glrs_pkg::prod_t'(a2_r) * glrs_pkg::prod_t'(gate2_r);
  assign pa_nxt = glrs_pkg::prod_t'(a2_r) * glrs_pkg::prod_t'(aux2_r);

  assign cell_nxt = glrs_pkg::sat_add(mg4_r, value4_r);
  assign wr_data  = mode4_r ? mg4_r : cell_nxt;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[ch4_r] <= wr_data;
    end
    if (in_acc) begin
      rd_data_r <= mem[in_channel];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_free) begin
        v1_r <= in_acc;
      end
      if (en1) begin
        v2_r <= v1_r;
      end
      if (en2) begin
        v3_r <= v2_r;
      end
      if (en3) begin
        v4_r <= v3_r;
      end
      if (en4) begin
        out_valid_r <= v4_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode1_r  <= in_mode;
      ch1_r    <= in_channel;
      start1_r <= in_seq_start;
      end1_r   <= in_seq_end;
      gate1_r  <= in_gate;
      value1_r <= in_value;
      aux1_r   <= in_aux;
    end
    if (en1 && v1_r) begin
      mode2_r  <= mode1_r;
      ch2_r    <= ch1_r;
      end2_r   <= end1_r;
      a2_r     <= opnd_nxt;
      gate2_r  <= gate1_r;
      value2_r <= value1_r;
      aux2_r   <= aux1_r;
    end
    if (en2 && v2_r) begin
      mode3_r  <= mode2_r;
      ch3_r    <= ch2_r;
      end3_r   <= end2_r;
      pg3_r    <= pg_nxt;
      pa3_r    <= pa_nxt;
      a3_r     <= a2_r;
      value3_r <= value2_r;
    end
    if (en3 && v3_r) begin
      mode4_r  <= mode3_r;
      ch4_r    <= ch3_r;
      end4_r   <= end3_r;
      mg4_r    <= glrs_pkg::round_sat(pg3_r);
      ma4_r    <= glrs_pkg::round_sat(pa3_r);
      a4_r     <= a3_r;
      value4_r <= value3_r;
    end
    if (wr_en) begin
      cell_out_r        <= mode4_r ? '0 : cell_nxt;
      grad_input_r      <= mode4_r ? a4_r : '0;
      grad_gate_r       <= mode4_r ? ma4_r : '0;
      grad_init_r       <= (mode4_r && end4_r) ? mg4_r : '0;
      grad_init_valid_r <= mode4_r && end4_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_cell_out        = cell_out_r;
  assign out_grad_input      = grad_input_r;
  assign out_grad_gate       = grad_gate_r;
  assign out_grad_init       = grad_init_r;
  assign out_grad_init_valid = grad_init_valid_r;

  // a store read never meets a write to the same entry
  `GLRS_ASSERT_SAME(a_no_rw_clash, clk, rst_n, in_acc && wr_en, in_channel != ch4_r)
  // an accepted beat is in the first stage next cycle
  `GLRS_ASSERT_NEXT(a_accept_lands, clk, rst_n, in_acc, v1_r)
  // a written-back beat shows on the output next cycle
  `GLRS_ASSERT_NEXT(a_write_to_out, clk, rst_n, wr_en, out_valid_r)

endmodule

>>> test/tb_gated_linear_recurrence_scan_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gated_linear_recurrence_scan_core
// self-checking bench for the gated linear recurrence scan core
//
// a short table of hand-picked beats (saturation, rounding ties, sequence
// flags in both modes) is followed by random forward and backward sequences
// interleaved over several channels, with stray beats mixed in. every
// accepted beat is run through a local Q16.16 model of the recurrence and
// each result beat is compared field by field, in order. both sides idle at
// random; the result side also holds off for a long stretch to fill the core.
// ----------------------------------------------------------------------------
module tb_gated_linear_recurrence_scan_core;

  typedef glrs_pkg::data_t data_t;
  typedef glrs_pkg::chan_t chan_t;

  localparam int    CHANNELS       = glrs_pkg::CHANNELS;
  localparam int    FRAC_BITS      = glrs_pkg::FRAC_BITS;
  localparam data_t DATA_MAX       = glrs_pkg::DATA_MAX;
  localparam data_t DATA_MIN       = glrs_pkg::DATA_MIN;
  localparam bit    MODE_FWD       = 1'b0;
  localparam bit    MODE_BWD       = 1'b1;
  localparam int    LANES          = 4;
  localparam int    HOLD_CYCLES    = 60;
  localparam int    WATCHDOG_LIMIT = 1000;
  localparam int    DRAIN_CYCLES   = 8;
  localparam data_t ONE            = 32'sh0001_0000;
  localparam data_t HALF           = 32'sh0000_8000;

  typedef struct {
    bit    mode;
    chan_t channel;
    bit    seq_start;
    bit    seq_end;
    data_t gate;
    data_t value;
    data_t aux;
  } scan_beat_t;

  typedef struct {
    data_t cell_out;
    data_t grad_input;
    data_t grad_gate;
    data_t grad_init;
    bit    grad_init_valid;
  } scan_result_t;

  typedef struct {
    scan_beat_t   beat;
    bit           typed;
    scan_result_t want;
  } vector_row_t;

  logic  clk          = 1'b0;
  logic  rst_n        = 1'b0;
  logic  in_valid     = 1'b0;
  logic  in_mode      = 1'b0;
  chan_t in_channel   = '0;
  logic  in_seq_start = 1'b0;
  logic  in_seq_end   = 1'b0;
  data_t in_gate      = '0;
  data_t in_value     = '0;
  data_t in_aux       = '0;
  logic  out_stall    = 1'b0;
  logic  in_stall;
  logic  out_valid;
  data_t out_cell_out;
  data_t out_grad_input;
  data_t out_grad_gate;
  data_t out_grad_init;
  logic  out_grad_init_valid;

  // local copy of the per-channel word and whether any beat has set it
  data_t chan_word [CHANNELS];
  bit    chan_written [CHANNELS];

  scan_result_t due_results [$];
  vector_row_t  vectors [$];
  scan_result_t no_result;

  int    lane_left [LANES];
  chan_t lane_ch [LANES];
  bit    lane_mode [LANES];

  bit tx_calm  = 1'b0;
  bit rx_calm  = 1'b0;
  bit hold_arm = 1'b0;
  int hold_left;
  int quiet_cycles;
  int errors;
  int n_fwd;
  int n_bwd;
  int n_init;
  int blocked_cycles;

  always #1 clk = ~clk;

  gated_linear_recurrence_scan_core uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_mode             (in_mode),
    .in_channel          (in_channel),
    .in_seq_start        (in_seq_start),
    .in_seq_end          (in_seq_end),
    .in_gate             (in_gate),
    .in_value            (in_value),
    .in_aux              (in_aux),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_cell_out        (out_cell_out),
    .out_grad_input      (out_grad_input),
    .out_grad_gate       (out_grad_gate),
    .out_grad_init       (out_grad_init),
    .out_grad_init_valid (out_grad_init_valid)
  );

  function automatic data_t clamp32(longint v);
    if (v > longint'(DATA_MAX)) begin
      return DATA_MAX;
    end
    if (v < longint'(DATA_MIN)) begin
      return DATA_MIN;
    end
    return data_t'(v);
  endfunction

  // exact product, round half up, then floor shift
  function automatic data_t qmul(data_t a, data_t b);
    longint p;
    p = longint'(a) * longint'(b) + (longint'(1) <<< (FRAC_BITS - 1));
    return clamp32(p >>> FRAC_BITS);
  endfunction

  function automatic data_t qadd(data_t a, data_t b);
    return clamp32(longint'(a) + longint'(b));
  endfunction

  function automatic scan_result_t recurrence_step(scan_beat_t b);
    scan_result_t r;
    data_t        prev;
    data_t        carry;
    data_t        grad;
    data_t        nxt;
    r.cell_out        = '0;
    r.grad_input      = '0;
    r.grad_gate       = '0;
    r.grad_init       = '0;
    r.grad_init_valid = 1'b0;
    if (b.mode == MODE_FWD) begin
      prev = b.seq_start ? b.aux : chan_word[b.channel];
      r.cell_out = qadd(qmul(prev, b.gate), b.value);
      chan_word[b.channel] = r.cell_out;
    end else begin
      // last time step starts from a zero carry
      carry = b.seq_start ? data_t'(0) : chan_word[b.channel];
      grad  = qadd(b.value, carry);
      nxt   = qmul(grad, b.gate);
      r.grad_input = grad;
      r.grad_gate  = qmul(grad, b.aux);
      chan_word[b.channel] = nxt;
      if (b.seq_end) begin
        r.grad_init       = nxt;
        r.grad_init_valid = 1'b1;
      end
    end
    chan_written[b.channel] = 1'b1;
    return r;
  endfunction

  function automatic data_t pick_word();
    case ($urandom_range(7))
      0:       return DATA_MAX;
      1:       return DATA_MIN;
      2:       return '0;
      3, 4:    return data_t'($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
      default: return data_t'($urandom);
    endcase
  endfunction

  // mostly well-formed sequences on a few lanes, some stray beats
  function automatic scan_beat_t next_beat();
    scan_beat_t b;
    int         k;
    k       = $urandom_range(LANES - 1);
    b.gate  = ($urandom_range(3) == 0) ? pick_word() : data_t'($urandom_range(32'h0001_0000));
    b.value = pick_word();
    b.aux   = pick_word();
    if ($urandom_range(99) < 15) begin
      // never read a channel that no start has opened
      b.mode      = 1'($urandom_range(1));
      b.channel   = chan_t'($urandom_range(CHANNELS - 1));
      b.seq_start = chan_written[b.channel] ? 1'($urandom_range(1)) : 1'b1;
      b.seq_end   = 1'($urandom_range(1));
      return b;
    end
    if (lane_left[k] == 0) begin
      lane_mode[k] = 1'($urandom_range(1));
      lane_ch[k]   = ($urandom_range(3) == 0) ? chan_t'($urandom_range(3))
                                              : chan_t'($urandom_range(CHANNELS - 1));
      lane_left[k] = $urandom_range(1, 10);
      b.seq_start  = 1'b1;
    end else begin
      b.seq_start = 1'b0;
    end
    lane_left[k] = lane_left[k] - 1;
    b.mode    = lane_mode[k];
    b.channel = lane_ch[k];
    b.seq_end = (b.mode == MODE_BWD) ? (lane_left[k] == 0) : 1'($urandom_range(1));
    return b;
  endfunction

  function automatic void add_row(bit mode, chan_t ch, bit st, bit en, data_t g, data_t v,
                                  data_t a, bit typed = 1'b0, data_t c = '0, data_t gi = '0,
                                  data_t gg = '0, data_t gn = '0, bit gv = 1'b0);
    vector_row_t row;
    row.beat.mode            = mode;
    row.beat.channel         = ch;
    row.beat.seq_start       = st;
    row.beat.seq_end         = en;
    row.beat.gate            = g;
    row.beat.value           = v;
    row.beat.aux             = a;
    row.typed                = typed;
    row.want.cell_out        = c;
    row.want.grad_input      = gi;
    row.want.grad_gate       = gg;
    row.want.grad_init       = gn;
    row.want.grad_init_valid = gv;
    vectors.push_back(row);
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endfunction

  task automatic send_beat(scan_beat_t b, bit typed, scan_result_t want);
    scan_result_t r;
    in_valid     <= 1'b1;
    in_mode      <= b.mode;
    in_channel   <= b.channel;
    in_seq_start <= b.seq_start;
    in_seq_end   <= b.seq_end;
    in_gate      <= b.gate;
    in_value     <= b.value;
    in_aux       <= b.aux;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    r = recurrence_step(b);
    due_results.push_back(typed ? want : r);
    if (b.mode == MODE_BWD) begin
      n_bwd++;
    end else begin
      n_fwd++;
    end
  endtask

  task automatic pause_sender();
    while (!tx_calm && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // result side: check beats, random stalls, one long hold-off on request
  always @(posedge clk) begin
    scan_result_t w;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (due_results.size() == 0) begin
        $display("%0t: result beat with nothing expected, cell_out %h", $time, out_cell_out);
        errors++;
      end else begin
        w = due_results.pop_front();
        check_field("cell_out", w.cell_out, out_cell_out);
        check_field("grad_input", w.grad_input, out_grad_input);
        check_field("grad_gate", w.grad_gate, out_grad_gate);
        check_field("grad_init", w.grad_init, out_grad_init);
        check_field("grad_init_valid", 32'(w.grad_init_valid), 32'(out_grad_init_valid));
        if (w.grad_init_valid) begin
          n_init++;
        end
      end
    end
    if (in_valid && in_stall === 1'b1) begin
      blocked_cycles++;
    end
    if (hold_arm) begin
      hold_left = HOLD_CYCLES;
      hold_arm  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !rx_calm && ($urandom_range(99) < 23);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && out_stall === 1'b0)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    no_result = '{default: '0};
    //      mode      ch      st    en    gate          value         aux
    add_row(MODE_FWD, 8'd0,   1'b1, 1'b0, '0,           32'sd5,       DATA_MAX,
            1'b1, 32'sd5);
    add_row(MODE_FWD, 8'd0,   1'b0, 1'b0, ONE,          ONE,          '0);
    add_row(MODE_FWD, 8'd1,   1'b1, 1'b0, DATA_MAX,     DATA_MAX,     DATA_MAX,
            1'b1, DATA_MAX);
    add_row(MODE_FWD, 8'd2,   1'b1, 1'b0, DATA_MIN,     DATA_MIN,     DATA_MAX,
            1'b1, DATA_MIN);
    add_row(MODE_FWD, 8'd3,   1'b1, 1'b0, DATA_MIN,     -32'sd1,      DATA_MIN,
            1'b1, 32'sh7fff_fffe);
    add_row(MODE_FWD, 8'd3,   1'b0, 1'b1, DATA_MIN,     DATA_MIN,     '0);
    // rounding ties either side of zero
    add_row(MODE_FWD, 8'd4,   1'b1, 1'b0, 32'sd1,       '0,           HALF);
    add_row(MODE_FWD, 8'd4,   1'b1, 1'b0, 32'sd1,       '0,           -HALF);
    add_row(MODE_FWD, 8'd4,   1'b1, 1'b0, 32'sd1,       '0,           -HALF - 32'sd1);
    // single-step backward sequence
    add_row(MODE_BWD, 8'd5,   1'b1, 1'b1, 2 * ONE,      ONE,          3 * ONE,
            1'b1, '0, ONE, 3 * ONE, 2 * ONE, 1'b1);
    add_row(MODE_BWD, 8'd6,   1'b1, 1'b0, HALF,         4 * ONE,      -ONE);
    add_row(MODE_BWD, 8'd6,   1'b0, 1'b0, ONE,          ONE,          ONE);
    add_row(MODE_BWD, 8'd6,   1'b0, 1'b1, ONE,          '0,           '0);
    add_row(MODE_BWD, 8'd7,   1'b1, 1'b1, DATA_MAX,     DATA_MAX,     DATA_MAX,
            1'b1, '0, DATA_MAX, DATA_MAX, DATA_MAX, 1'b1);
    add_row(MODE_BWD, 8'd7,   1'b0, 1'b0, DATA_MIN,     DATA_MAX,     DATA_MIN,
            1'b1, '0, DATA_MAX, DATA_MIN, '0, 1'b0);
    add_row(MODE_BWD, 8'd7,   1'b0, 1'b1, '0,           DATA_MIN,     '0,
            1'b1, '0, DATA_MIN, '0, '0, 1'b1);
    add_row(MODE_FWD, 8'd255, 1'b1, 1'b0, ONE,          -32'sd1,      -ONE);
    add_row(MODE_FWD, 8'd255, 1'b0, 1'b1, -ONE,         32'sh1234_5678, '0);
    // backward step picks up a word left by a forward pass
    add_row(MODE_BWD, 8'd255, 1'b0, 1'b0, 32'sh5555_5555, 32'sh7654_3210, 32'shAAAA_AAAA);
    add_row(MODE_FWD, 8'd0,   1'b1, 1'b1, 32'shFFFF_FFFF, '0,         32'shAAAA_AAAA);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (vectors[i]) begin
      send_beat(vectors[i].beat, vectors[i].typed, vectors[i].want);
      pause_sender();
    end

    repeat (300) begin
      send_beat(next_beat(), 1'b0, no_result);
      pause_sender();
    end

    // result side holds off while beats keep coming, so the core backs up
    hold_arm = 1'b1;
    tx_calm  = 1'b1;
    repeat (40) send_beat(next_beat(), 1'b0, no_result);
    tx_calm = 1'b0;

    // let everything drain before carrying on
    in_valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);

    tx_calm = 1'b1;
    rx_calm = 1'b1;
    repeat (150) send_beat(next_beat(), 1'b0, no_result);
    tx_calm = 1'b0;
    rx_calm = 1'b0;

    repeat (250) begin
      send_beat(next_beat(), 1'b0, no_result);
      pause_sender();
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (due_results.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d forward and %0d backward beats, %0d with an initial-cell gradient",
             n_fwd, n_bwd, n_init);
    $display("input side was held off for %0d cycles; %0d mismatches", blocked_cycles, errors);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
